// ===== hw/rtl/kf_pkg.sv =====
// Shared types, constants and helper functions for the angle Kalman filter.
`default_nettype none
package kf_pkg;

    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CYCLES = 28;  // 56 quotient bits, two per cycle
    localparam int DIV_CNT_W  = 5;

    localparam logic OP_UPDATE    = 1'b0;
    localparam logic OP_SET_ANGLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 24'd16777;
    localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 24'd50332;
    localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 24'd503316;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_GAIN,
        ST_DONE
    } kf_state_t;

    typedef enum logic [3:0] {
        STEP_RATE,
        STEP_DTBB,
        STEP_INNER,
        STEP_BIAS_NOISE,
        STEP_ANGLE_CORR,
        STEP_BIAS_CORR,
        STEP_AA_CORR,
        STEP_AB_CORR,
        STEP_BA_CORR,
        STEP_BB_CORR
    } kf_step_t;

    typedef struct packed {
        logic     load;
        logic     set_angle;
        logic     mul;
        logic     acc;
        kf_step_t step;
        logic     div_init;
        logic     div_step;
        logic     gain;
        logic     out_load;
    } kf_cmd_t;

    typedef struct packed {
        logic out_full;
    } kf_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [31:0] r;
        if (x > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Saturates a signed quotient given as magnitude and sign.
    function automatic logic signed [31:0] gain_sat(input logic [55:0] q, input logic neg,
                                                    input logic zero);
        logic signed [31:0] r;
        if (zero) begin
            r = '0;
        end else if (!neg) begin
            r = (q > 56'd2147483647) ? 32'sh7FFFFFFF : q[31:0];
        end else begin
            r = (q > 56'd2147483648) ? 32'sh80000000 : -q[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kf_ctrl.sv =====
// Sequencer that steps the filter datapath through prediction, gains and correction.
`default_nettype none
module kf_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_op,
    output logic                 s_ready,
    input  wire logic            m_ready,
    input  wire kf_pkg::kf_stat_t stat,
    output kf_pkg::kf_cmd_t      cmd
);
    import kf_pkg::*;

    kf_state_t state_reg, state_next;
    kf_step_t  step_reg, step_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_RATE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_SET_ANGLE) ? ST_DONE : ST_MUL;
                    step_next  = STEP_RATE;
                end
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                if (step_reg == STEP_BIAS_NOISE) begin
                    state_next = ST_DIV_INIT;
                    step_next  = kf_step_t'(step_reg + 4'd1);
                end else if (step_reg == STEP_BB_CORR) begin
                    state_next = ST_DONE;
                    step_next  = STEP_RATE;
                end else begin
                    state_next = ST_MUL;
                    step_next  = kf_step_t'(step_reg + 4'd1);
                end
            end
            ST_DIV_INIT: begin
                state_next = ST_DIV_RUN;
                cnt_next   = '0;
            end
            ST_DIV_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: state_next = ST_MUL;
            ST_DONE: begin
                if (!stat.out_full || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.step  = step_reg;
        s_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load      = s_valid;
                cmd.set_angle = s_valid && (s_op == OP_SET_ANGLE);
            end
            ST_MUL:      cmd.mul      = 1'b1;
            ST_ACC:      cmd.acc      = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV_RUN:  cmd.div_step = 1'b1;
            ST_GAIN:     cmd.gain     = 1'b1;
            ST_DONE:     cmd.out_load = !stat.out_full || m_ready;
            default:     cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/kf_datapath.sv =====
// Filter state, noise registers, shared multiplier, gain divider and output register.
`default_nettype none
module kf_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [kf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kf_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic signed [31:0]             s_measured_angle,
    input  wire logic signed [31:0]             s_measured_rate,
    input  wire logic [15:0]                    s_time_step,
    input  wire kf_pkg::kf_cmd_t                cmd,
    output kf_pkg::kf_stat_t                    stat,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [31:0]                  m_angle_estimate
);
    import kf_pkg::*;

    logic [CFG_W-1:0] apn_reg, bpn_reg, mn_reg;
    logic signed [31:0] angle_reg, bias_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [31:0] meas_angle_reg, meas_rate_reg;
    logic [15:0]        dt_reg;
    logic signed [32:0] dtbb_reg, y_reg;
    logic signed [31:0] aa_s_reg, ab_s_reg, k0_reg, k1_reg;
    logic signed [66:0] prod_reg;
    logic               mv_reg;
    logic signed [31:0] out_reg;

    // Divider: both gains share the divisor |s|.
    logic [32:0] d_reg;
    logic [33:0] r0_reg, r1_reg;
    logic [55:0] q0_reg, q1_reg;
    logic        neg0_reg, neg1_reg, szero_reg;

    logic signed [32:0] mul_a, rate, y_now;
    logic signed [33:0] mul_b, inner, s_sum;
    logic signed [67:0] rnd16, rnd24;
    logic [33:0] r0_n, r1_n, rt;
    logic [55:0] q0_n, q1_n;
    logic [31:0] abs_aa, abs_ba;

    assign rate  = 33'(meas_rate_reg) - 33'(bias_reg);
    assign inner = 34'(dtbb_reg) - 34'(ab_reg) - 34'(ba_reg) + $signed({10'd0, apn_reg});
    assign y_now = 33'(meas_angle_reg) - 33'(angle_reg);
    assign s_sum = 34'(aa_reg) + $signed({10'd0, mn_reg});
    assign abs_aa = aa_reg[31] ? 32'(-aa_reg) : 32'(aa_reg);
    assign abs_ba = ba_reg[31] ? 32'(-ba_reg) : 32'(ba_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_RATE:       begin mul_a = $signed({17'd0, dt_reg}); mul_b = 34'(rate); end
            STEP_DTBB:       begin mul_a = $signed({17'd0, dt_reg}); mul_b = 34'(bb_reg); end
            STEP_INNER:      begin mul_a = $signed({17'd0, dt_reg}); mul_b = inner; end
            STEP_BIAS_NOISE: begin
                mul_a = $signed({9'd0, bpn_reg});
                mul_b = $signed({18'd0, dt_reg});
            end
            STEP_ANGLE_CORR: begin mul_a = 33'(k0_reg); mul_b = 34'(y_reg); end
            STEP_BIAS_CORR:  begin mul_a = 33'(k1_reg); mul_b = 34'(y_reg); end
            STEP_AA_CORR:    begin mul_a = 33'(k0_reg); mul_b = 34'(aa_s_reg); end
            STEP_AB_CORR:    begin mul_a = 33'(k0_reg); mul_b = 34'(ab_s_reg); end
            STEP_BA_CORR:    begin mul_a = 33'(k1_reg); mul_b = 34'(aa_s_reg); end
            STEP_BB_CORR:    begin mul_a = 33'(k1_reg); mul_b = 34'(ab_s_reg); end
            default:         begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Round half up, then floor shift back to the target format.
    assign rnd16 = (68'(prod_reg) + 68'sd32768) >>> 16;
    assign rnd24 = (68'(prod_reg) + 68'sd8388608) >>> 24;

    always_comb begin
        r0_n = r0_reg;
        q0_n = q0_reg;
        r1_n = r1_reg;
        q1_n = q1_reg;
        rt   = '0;
        for (int i = 0; i < 2; i++) begin
            rt   = {r0_n[32:0], q0_n[55]};
            q0_n = {q0_n[54:0], 1'b0};
            if (rt >= 34'(d_reg)) begin
                rt      = rt - 34'(d_reg);
                q0_n[0] = 1'b1;
            end
            r0_n = rt;
            rt   = {r1_n[32:0], q1_n[55]};
            q1_n = {q1_n[54:0], 1'b0};
            if (rt >= 34'(d_reg)) begin
                rt      = rt - 34'(d_reg);
                q1_n[0] = 1'b1;
            end
            r1_n = rt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apn_reg   <= ANGLE_NOISE_RST;
            bpn_reg   <= BIAS_NOISE_RST;
            mn_reg    <= MEAS_NOISE_RST;
            angle_reg <= '0;
            bias_reg  <= '0;
            aa_reg    <= '0;
            ab_reg    <= '0;
            ba_reg    <= '0;
            bb_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ANGLE_NOISE: apn_reg <= cfg_wdata;
                    REG_BIAS_NOISE:  bpn_reg <= cfg_wdata;
                    REG_MEAS_NOISE:  mn_reg  <= cfg_wdata;
                    default:         ;
                endcase
            end
            if (cmd.set_angle) begin
                angle_reg <= s_measured_angle;
            end
            if (cmd.acc) begin
                case (cmd.step)
                    STEP_RATE:  angle_reg <= sat32(68'(angle_reg) + rnd16);
                    STEP_INNER: begin
                        aa_reg <= sat32(68'(aa_reg) + rnd16);
                        ab_reg <= sat32(68'(ab_reg) - 68'(dtbb_reg));
                        ba_reg <= sat32(68'(ba_reg) - 68'(dtbb_reg));
                    end
                    STEP_BIAS_NOISE: bb_reg    <= sat32(68'(bb_reg) + rnd16);
                    STEP_ANGLE_CORR: angle_reg <= sat32(68'(angle_reg) + rnd24);
                    STEP_BIAS_CORR:  bias_reg  <= sat32(68'(bias_reg) + rnd24);
                    STEP_AA_CORR:    aa_reg    <= sat32(68'(aa_reg) - rnd24);
                    STEP_AB_CORR:    ab_reg    <= sat32(68'(ab_reg) - rnd24);
                    STEP_BA_CORR:    ba_reg    <= sat32(68'(ba_reg) - rnd24);
                    STEP_BB_CORR:    bb_reg    <= sat32(68'(bb_reg) - rnd24);
                    default:         ;
                endcase
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            meas_angle_reg <= s_measured_angle;
            meas_rate_reg  <= s_measured_rate;
            dt_reg         <= s_time_step;
        end
        if (cmd.mul) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc && cmd.step == STEP_DTBB) begin
            dtbb_reg <= rnd16[32:0];
        end
        if (cmd.div_init) begin
            y_reg     <= y_now;
            aa_s_reg  <= aa_reg;
            ab_s_reg  <= ab_reg;
            d_reg     <= s_sum[33] ? 33'(-s_sum) : 33'(s_sum);
            szero_reg <= (s_sum == '0);
            neg0_reg  <= aa_reg[31] ^ s_sum[33];
            neg1_reg  <= ba_reg[31] ^ s_sum[33];
            q0_reg    <= {abs_aa, 24'd0};
            q1_reg    <= {abs_ba, 24'd0};
            r0_reg    <= '0;
            r1_reg    <= '0;
        end
        if (cmd.div_step) begin
            r0_reg <= r0_n;
            q0_reg <= q0_n;
            r1_reg <= r1_n;
            q1_reg <= q1_n;
        end
        if (cmd.gain) begin
            k0_reg <= gain_sat(q0_reg, neg0_reg, szero_reg);
            k1_reg <= gain_sat(q1_reg, neg1_reg, szero_reg);
        end
        if (cmd.out_load) begin
            out_reg <= angle_reg;
        end
    end

    assign stat.out_full    = mv_reg;
    assign m_valid          = mv_reg;
    assign m_angle_estimate = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/angle_kalman_filter.sv =====
// Top level of the two-state angle and gyro bias Kalman filter.
`default_nettype none
// Two-state Kalman filter in fixed point: each update word (measured angle Q16.16,
// gyro rate Q16.16, time step Q0.16) predicts and corrects the angle and bias
// estimates and returns the angle; a set-angle word only loads the angle estimate.
// An update runs four products through one shared 33x34 multiplier, sets up the
// gain divider, which produces two quotient bits per cycle for both gains at once,
// forms the gains, runs six more products and then loads the output register.
// A set-angle word goes straight to loading the output register.
// The next word is accepted once the sequencer is back in idle.
// One word is processed at a time; the next word is accepted while the previous
// result still waits in the output register, and a finished word waits until that
// register is read. Noise registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the filter is idle, as the block
// itself does not enforce this.
module angle_kalman_filter (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [kf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kf_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_op,
    input  wire logic signed [31:0]           s_measured_angle,
    input  wire logic signed [31:0]           s_measured_rate,
    input  wire logic [15:0]                  s_time_step,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [31:0]                m_angle_estimate
);
    import kf_pkg::*;

    kf_cmd_t  cmd;
    kf_stat_t stat;

    kf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kf_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_measured_angle (s_measured_angle),
        .s_measured_rate  (s_measured_rate),
        .s_time_step      (s_time_step),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_angle_estimate (m_angle_estimate)
    );

endmodule
`default_nettype wire

// ===== tb/angle_kalman_filter_checker.sv =====
// Checker for the angle Kalman filter: predicts every result and compares it.
module angle_kalman_filter_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [kf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_op,
    input  logic signed [31:0]           s_measured_angle,
    input  logic signed [31:0]           s_measured_rate,
    input  logic [15:0]                  s_time_step,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [31:0]           m_angle_estimate,
    output int                           fail_count,
    output int                           pending_count,
    output int                           checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import kf_pkg::*;

    typedef logic signed [79:0] wide_t;

    logic [CFG_W-1:0] angle_noise, bias_noise, meas_noise;
    logic signed [31:0] angle, bias, p_aa, p_ab, p_ba, p_bb;
    logic signed [31:0] angle_queue[$];

    function automatic logic signed [31:0] clamp32(wide_t x);
        if (x > 80'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -80'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // Round half up, then floor shift.
    function automatic wide_t round_down(wide_t x, int n);
        return (x + (wide_t'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] gain_of(wide_t num, wide_t s);
        if (s == 0) return '0;
        return clamp32((num <<< 24) / s);
    endfunction

    function automatic logic signed [31:0] next_angle(logic op, logic signed [31:0] meas_a,
                                                      logic signed [31:0] meas_r,
                                                      logic [15:0] step);
        wide_t dt, rate, dt_bb, inner, s, y, aa, ab;
        logic signed [31:0] k0, k1;
        dt = wide_t'(step);
        if (op == OP_SET_ANGLE) begin
            angle = meas_a;
        end else begin
            rate  = wide_t'(meas_r) - wide_t'(bias);
            angle = clamp32(wide_t'(angle) + round_down(dt * rate, 16));
            dt_bb = round_down(dt * wide_t'(p_bb), 16);
            inner = dt_bb - wide_t'(p_ab) - wide_t'(p_ba) + wide_t'(angle_noise);
            p_aa  = clamp32(wide_t'(p_aa) + round_down(dt * inner, 16));
            p_ab  = clamp32(wide_t'(p_ab) - dt_bb);
            p_ba  = clamp32(wide_t'(p_ba) - dt_bb);
            p_bb  = clamp32(wide_t'(p_bb) + round_down(wide_t'(bias_noise) * dt, 16));

            s  = wide_t'(p_aa) + wide_t'(meas_noise);
            k0 = gain_of(wide_t'(p_aa), s);
            k1 = gain_of(wide_t'(p_ba), s);

            y     = wide_t'(meas_a) - wide_t'(angle);
            angle = clamp32(wide_t'(angle) + round_down(wide_t'(k0) * y, 24));
            bias  = clamp32(wide_t'(bias) + round_down(wide_t'(k1) * y, 24));
            aa = wide_t'(p_aa);
            ab = wide_t'(p_ab);
            p_aa = clamp32(wide_t'(p_aa) - round_down(wide_t'(k0) * aa, 24));
            p_ab = clamp32(wide_t'(p_ab) - round_down(wide_t'(k0) * ab, 24));
            p_ba = clamp32(wide_t'(p_ba) - round_down(wide_t'(k1) * aa, 24));
            p_bb = clamp32(wide_t'(p_bb) - round_down(wide_t'(k1) * ab, 24));
        end
        return angle;
    endfunction

    assign pending_count = angle_queue.size();

    initial begin
        fail_count = 0;
        checked_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            angle_noise = ANGLE_NOISE_RST;
            bias_noise  = BIAS_NOISE_RST;
            meas_noise  = MEAS_NOISE_RST;
            angle = '0; bias = '0;
            p_aa = '0; p_ab = '0; p_ba = '0; p_bb = '0;
            angle_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (angle_queue.size() == 0) begin
                    $error("angle_estimate: unexpected word, actual %0d", m_angle_estimate);
                    fail_count++;
                end else begin
                    if (m_angle_estimate !== angle_queue[0]) begin
                        $error("angle_estimate: expected %0d, actual %0d",
                               angle_queue[0], m_angle_estimate);
                        fail_count++;
                    end
                    void'(angle_queue.pop_front());
                    checked_count++;
                end
            end
            if (s_valid && s_ready)
                angle_queue.push_back(next_angle(s_op, s_measured_angle, s_measured_rate,
                                                 s_time_step));
            if (cfg_we) begin
                case (cfg_index)
                    REG_ANGLE_NOISE: angle_noise = cfg_wdata;
                    REG_BIAS_NOISE:  bias_noise  = cfg_wdata;
                    REG_MEAS_NOISE:  meas_noise  = cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the angle Kalman filter: stimulus, flow control and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic aclk, aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic s_valid, s_ready, s_op;
    logic signed [31:0] s_measured_angle, s_measured_rate;
    logic [15:0] s_time_step;
    logic m_valid, m_ready;
    logic signed [31:0] m_angle_estimate;
    int fail_count, pending_count, checked_count;
    logic long_hold;
    int words_sent;

    angle_kalman_filter dut (.*);

    angle_kalman_filter_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("angle_kalman_filter verification failed");
        $finish;
    end

    // The receiver stalls on its own pattern and holds off for a long stretch on request.
    initial begin
        int mode;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            mode = $urandom_range(0, 3);
            if (mode == 0) m_ready <= 1'b1;
            else if (mode == 1) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Called at a rising edge; returns at the edge where the word is accepted.
    task automatic send_word(logic op, logic [31:0] a, logic [31:0] r, logic [15:0] dt);
        s_valid <= 1'b1;
        s_op <= op;
        s_measured_angle <= a;
        s_measured_rate <= r;
        s_time_step <= dt;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
            @(posedge aclk);
        end
        @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_noise(logic [CFG_W-1:0] qa, logic [CFG_W-1:0] qb,
                             logic [CFG_W-1:0] rm);
        drain();
        write_reg(REG_ANGLE_NOISE, qa);
        write_reg(REG_BIAS_NOISE, qb);
        write_reg(REG_MEAS_NOISE, rm);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 180 << 17)) - (90 << 17));
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom());
            default: return 16'($urandom_range(16, 1400));
        endcase
    endfunction

    task automatic random_block(int count);
        int gap;
        for (int i = 0; i < count; i++) begin
            send_word(($urandom_range(0, 9) == 0) ? OP_SET_ANGLE : OP_UPDATE,
                      pick_value(), pick_value(), pick_step());
            if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(0, 80);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0; s_op = OP_UPDATE;
        s_measured_angle = '0; s_measured_rate = '0; s_time_step = '0;
        long_hold = 1'b0;
        words_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of every field, set angle, zero and full time steps.
        send_word(OP_SET_ANGLE, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
        send_word(OP_UPDATE, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
        send_word(OP_UPDATE, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
        send_word(OP_UPDATE, 32'h00000000, 32'h00000000, 16'h0000);
        send_word(OP_SET_ANGLE, 32'h80000000, 32'h7FFFFFFF, 16'h0000);
        send_word(OP_UPDATE, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0001);
        send_word(OP_UPDATE, 32'h00010000, 32'h00050000, 16'd655);
        send_word(OP_SET_ANGLE, 32'h00000000, 32'h00000000, 16'h0000);
        send_word(OP_UPDATE, 32'h002D0000, 32'hFFF60000, 16'd1000);
        drain();

        // Tiny measurement noise and no process noise drive the gains to their limits.
        set_noise(24'd0, 24'd0, 24'd1);
        send_word(OP_UPDATE, 32'h00100000, 32'h00000000, 16'h0000);
        send_word(OP_UPDATE, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
        send_word(OP_UPDATE, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
        drain();
        write_reg(REG_UNUSED, 24'hFFFFFF);
        random_block(60);

        // Let the filter fill up while the receiver holds off.
        long_hold = 1'b1;
        random_block(40);
        drain();

        set_noise(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_block(100);
        set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
        random_block(150);
        set_noise(24'($urandom()), 24'($urandom()), 24'($urandom_range(1, 24'hFFFFFF)));
        random_block(150);

        drain();
        repeat (100) @(posedge aclk);
        $display("Sent %0d words over five noise settings and checked %0d angle results.",
                 words_sent, checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("angle_kalman_filter verification clean");
        else
            $display("angle_kalman_filter verification failed");
        $finish;
    end

endmodule
